### hdl/rcw_pkg.sv
// Package for the Reno congestion window block: widths, reset values and
// sequencer state type. No dependencies.
package rcw_pkg;

    localparam int unsigned WIN_W     = 16;
    localparam int unsigned DIV_W     = WIN_W + 1;
    localparam int unsigned CNT_W     = $clog2(DIV_W);

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(10);
    localparam logic [WIN_W-1:0] THRESH_RESET = {WIN_W{1'b1}};
    localparam logic [WIN_W-1:0] CLAMP_RESET  = {WIN_W{1'b1}};
    localparam logic [WIN_W-1:0] MIN_THRESH   = WIN_W'(2);
    localparam logic [WIN_W-1:0] MIN_CLAMP    = WIN_W'(1);
    localparam logic [CNT_W-1:0] DIV_LAST     = CNT_W'(DIV_W - 1);

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_LOSS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOW,
        S_AVOID,
        S_DIV,
        S_FINAL,
        S_DONE
    } t_state;

endpackage

### hdl/reno_congestion_window.sv
// Reno congestion window: one event in, one window/threshold result out. Depends on rcw_pkg.
// An ack that reaches congestion avoidance passes S_SLOW, S_AVOID, the bit-serial restoring
// divider in S_DIV, S_FINAL and S_DONE; loss events, ignored acks and acks used up in slow
// start go from S_SLOW straight to S_DONE. One event in flight; the next is taken the cycle
// after the result is loaded, and S_DONE waits while the output is stalled.
// Reset (synchronous, active low): window 10, threshold 65535, counter 0, clamp 65535.
module reno_congestion_window (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [rcw_pkg::WIN_W-1:0] i_cfg_window_clamp,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_kind,
    input  logic [rcw_pkg::WIN_W-1:0] i_acked_packets,
    input  logic                      i_cwnd_limited,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [rcw_pkg::WIN_W-1:0] o_window,
    output logic [rcw_pkg::WIN_W-1:0] o_threshold
);
    import rcw_pkg::*;

    t_state             r_state, n_state;
    logic [WIN_W-1:0]   r_clamp, n_clamp;
    logic [WIN_W-1:0]   r_cwnd, n_cwnd;
    logic [WIN_W-1:0]   r_ssth, n_ssth;
    logic [WIN_W-1:0]   r_count, n_count;
    logic               r_kind, n_kind;
    logic               r_limited, n_limited;
    logic [WIN_W-1:0]   r_acked, n_acked;
    logic [DIV_W-1:0]   r_base, n_base;
    logic [WIN_W-1:0]   r_rem, n_rem;
    logic [DIV_W-1:0]   r_quo, n_quo;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic [WIN_W-1:0]   r_out_window, n_out_window;
    logic [WIN_W-1:0]   r_out_thresh, n_out_thresh;

    logic [WIN_W-1:0]   lim;
    logic [DIV_W-1:0]   ss_sum;
    logic [DIV_W-1:0]   ss_left;
    logic [WIN_W-1:0]   ss_grown;
    logic [WIN_W-1:0]   half;
    logic [WIN_W-1:0]   ca_count;
    logic [DIV_W-1:0]   ca_sum;
    logic [DIV_W-1:0]   trial;
    logic [DIV_W-1:0]   trial_diff;
    logic               trial_ge;
    logic [DIV_W:0]     wnd_sum;

    assign lim         = (r_clamp == '0) ? MIN_CLAMP : r_clamp;
    assign ss_sum      = {1'b0, r_cwnd} + {1'b0, r_acked};
    assign ss_left     = ss_sum - {1'b0, r_ssth};
    assign ss_grown    = (ss_sum > {1'b0, r_ssth}) ? r_ssth : ss_sum[WIN_W-1:0];
    assign half        = {1'b0, r_cwnd[WIN_W-1:1]};
    assign ca_count    = (r_count >= r_cwnd) ? '0 : r_count;
    assign ca_sum      = {1'b0, ca_count} + {1'b0, r_acked};
    assign trial       = {r_rem, r_quo[DIV_W-1]};
    assign trial_diff  = trial - {1'b0, r_cwnd};
    assign trial_ge    = (trial >= {1'b0, r_cwnd});
    assign wnd_sum     = {1'b0, r_base} + {1'b0, r_quo};

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_window    = r_out_window;
    assign o_threshold = r_out_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clamp     <= CLAMP_RESET;
            r_cwnd      <= WINDOW_RESET;
            r_ssth      <= THRESH_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_clamp     <= n_clamp;
            r_cwnd      <= n_cwnd;
            r_ssth      <= n_ssth;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_kind       <= n_kind;
        r_limited    <= n_limited;
        r_acked      <= n_acked;
        r_base       <= n_base;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_out_window <= n_out_window;
        r_out_thresh <= n_out_thresh;
    end

    always_comb begin
        n_state      = r_state;
        n_clamp      = r_clamp;
        n_cwnd       = r_cwnd;
        n_ssth       = r_ssth;
        n_count      = r_count;
        n_kind       = r_kind;
        n_limited    = r_limited;
        n_acked      = r_acked;
        n_base       = r_base;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid;
        n_out_window = r_out_window;
        n_out_thresh = r_out_thresh;

        if (i_cfg_valid) begin
            n_clamp = i_cfg_window_clamp;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind    = i_kind;
                    n_limited = i_cwnd_limited;
                    n_acked   = i_acked_packets;
                    n_state   = S_SLOW;
                end
            end
            S_SLOW: begin
                if (r_kind == KIND_LOSS) begin
                    n_ssth  = (half > MIN_THRESH) ? half : MIN_THRESH;
                    n_state = S_DONE;
                end else if (!r_limited) begin
                    n_state = S_DONE;
                end else if (r_cwnd < r_ssth) begin
                    // grow toward threshold, pass the leftover on
                    n_cwnd  = (ss_grown < lim) ? ss_grown : lim;
                    n_acked = (ss_sum > {1'b0, r_ssth}) ? ss_left[WIN_W-1:0] : '0;
                    n_state = (ss_sum > {1'b0, r_ssth}) ? S_AVOID : S_DONE;
                end else begin
                    n_state = S_AVOID;
                end
            end
            S_AVOID: begin
                n_base  = {1'b0, r_cwnd} + ((r_count >= r_cwnd) ? DIV_W'(1) : '0);
                n_quo   = ca_sum;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // one quotient bit per cycle
                n_rem = trial_ge ? trial_diff[WIN_W-1:0] : trial[WIN_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], trial_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                n_cwnd  = (wnd_sum > {2'b00, lim}) ? lim : wnd_sum[WIN_W-1:0];
                n_count = r_rem;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_window = r_cwnd;
                    n_out_thresh = r_ssth;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### tb/tb_reno_congestion_window.sv
// Testbench for reno_congestion_window: directed and random ack/loss events with
// random stalls on both sides, checked against an in-bench window/threshold model.
// Depends on rcw_pkg and the reno_congestion_window RTL.
`timescale 1ns / 1ps

module tb_reno_congestion_window;
    import rcw_pkg::*;

    typedef logic [WIN_W-1:0] t_win;

    typedef struct packed {
        logic kind;
        t_win acked;
        logic limited;
    } t_cc_event;

    typedef struct packed {
        t_win window;
        t_win threshold;
    } t_wnd_thr;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 25;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    t_win i_cfg_window_clamp = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_kind = KIND_ACK;
    t_win i_acked_packets = '0;
    logic i_cwnd_limited = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_win o_window;
    t_win o_threshold;

    t_cc_event event_q[$];
    t_wnd_thr wnd_thr_q[$];

    int unsigned clamp_m = CLAMP_RESET;
    int unsigned cwnd_m = WINDOW_RESET;
    int unsigned ssthresh_m = THRESH_RESET;
    int unsigned avoid_cnt_m = 0;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int n_sent = 0;
    int n_acc = 0;
    int n_cfg = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;
    logic in_fire = 1'b0;

    reno_congestion_window i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_window_clamp (i_cfg_window_clamp),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_kind             (i_kind),
        .i_acked_packets    (i_acked_packets),
        .i_cwnd_limited     (i_cwnd_limited),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_window           (o_window),
        .o_threshold        (o_threshold)
    );

    always #1 i_clk = ~i_clk;

    function automatic void reno_update(input t_cc_event ev);
        int unsigned lim;
        int unsigned acked;
        int unsigned grown;
        int unsigned w;
        int unsigned wnd;
        int unsigned delta;
        logic go_on;
        lim = (clamp_m == 0) ? 1 : clamp_m;
        acked = ev.acked;
        if (ev.kind == KIND_LOSS) begin
            ssthresh_m = ((cwnd_m >> 1) > MIN_THRESH) ? (cwnd_m >> 1) : MIN_THRESH;
        end else if (ev.limited) begin
            go_on = 1'b1;
            if (cwnd_m < ssthresh_m) begin
                grown = cwnd_m + acked;
                if (grown > ssthresh_m) begin
                    grown = ssthresh_m;
                end
                acked = acked - (grown - cwnd_m);
                cwnd_m = (grown < lim) ? grown : lim;
                if (acked == 0) begin
                    go_on = 1'b0;
                end
            end
            if (go_on) begin
                w = (cwnd_m == 0) ? 1 : cwnd_m;
                wnd = cwnd_m;
                if (avoid_cnt_m >= w) begin
                    avoid_cnt_m = 0;
                    wnd = wnd + 1;
                end
                avoid_cnt_m = avoid_cnt_m + acked;
                if (avoid_cnt_m >= w) begin
                    delta = avoid_cnt_m / w;
                    avoid_cnt_m = avoid_cnt_m - delta * w;
                    wnd = wnd + delta;
                end
                cwnd_m = (wnd < lim) ? wnd : lim;
                avoid_cnt_m = avoid_cnt_m & 32'h1FFFF;
            end
        end
    endfunction

    // Monitor: record transfers, update the model, check results.
    always @(posedge i_clk) begin
        t_cc_event ev;
        t_wnd_thr got;
        t_wnd_thr want;
        cycle_cnt = cycle_cnt + 1;
        if (!i_rst_n) begin
            in_fire = 1'b0;
        end else begin
            in_fire = i_in_valid && o_in_ready;
            if (i_cfg_valid && o_cfg_ready) begin
                clamp_m = i_cfg_window_clamp;
                n_cfg = n_cfg + 1;
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_window, o_threshold};
                if (wnd_thr_q.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10) begin
                        $display("unexpected result: window %0d threshold %0d",
                                 got.window, got.threshold);
                    end
                end else begin
                    want = wnd_thr_q.pop_front();
                    if (want != got) begin
                        err_cnt = err_cnt + 1;
                        if (err_cnt <= 10) begin
                            $display("mismatch: window exp %0d got %0d, threshold exp %0d got %0d",
                                     want.window, got.window, want.threshold, got.threshold);
                        end
                    end
                end
            end
            if (in_fire) begin
                ev = '{i_kind, i_acked_packets, i_cwnd_limited};
                reno_update(ev);
                wnd_thr_q.push_back('{t_win'(cwnd_m), t_win'(ssthresh_m)});
                n_acc = n_acc + 1;
            end
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Driver: hold until transfer, then advance or idle.
    always @(negedge i_clk) begin
        t_cc_event ev;
        if (i_rst_n && !(i_in_valid && !in_fire)) begin
            if (event_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                ev = event_q.pop_front();
                i_in_valid <= 1'b1;
                i_kind <= ev.kind;
                i_acked_packets <= ev.acked;
                i_cwnd_limited <= ev.limited;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= i_rst_n && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    task automatic queue_event(input logic kind, input t_win acked, input logic limited);
        event_q.push_back('{kind, acked, limited});
        n_sent = n_sent + 1;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (n_acc != n_sent || wnd_thr_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_clamp(input t_win value);
        int target;
        target = n_cfg + 1;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_window_clamp <= value;
        do @(negedge i_clk); while (n_cfg != target);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_cc_event ev;
        t_win clamp_v;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        src_idle_pct = 19;
        snk_idle_pct = 57;

        queue_event(KIND_ACK, 100, 1'b0);
        queue_event(KIND_ACK, 0, 1'b1);
        queue_event(KIND_ACK, 5, 1'b1);
        queue_event(KIND_LOSS, 0, 1'b0);
        queue_event(KIND_ACK, 20, 1'b1);
        queue_event(KIND_ACK, 16'hFFFF, 1'b1);
        queue_event(KIND_LOSS, 16'hFFFF, 1'b1);
        queue_event(KIND_ACK, 16'hFFFF, 1'b1);
        queue_event(KIND_ACK, 1, 1'b1);
        wait_drained();
        write_clamp(MIN_CLAMP);
        queue_event(KIND_ACK, 1, 1'b1);
        queue_event(KIND_LOSS, 0, 1'b0);
        queue_event(KIND_ACK, 16'hFFFF, 1'b1);
        queue_event(KIND_ACK, 0, 1'b1);
        wait_drained();
        write_clamp('0);
        queue_event(KIND_ACK, 7, 1'b1);
        queue_event(KIND_LOSS, 16'hFFFF, 1'b0);
        queue_event(KIND_ACK, 3, 1'b0);
        wait_drained();
        write_clamp(CLAMP_RESET);
        queue_event(KIND_ACK, 3, 1'b1);
        queue_event(KIND_ACK, 500, 1'b1);
        queue_event(KIND_ACK, 40000, 1'b1);
        wait_drained();
        write_clamp(5);
        queue_event(KIND_ACK, 1, 1'b1);
        queue_event(KIND_ACK, 2, 1'b1);
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            @(posedge i_clk);
            src_idle_pct = (p == 0) ? 19 : (p == 1) ? 57 : 0;
            snk_idle_pct = (p == 0) ? 57 : (p == 1) ? 19 : 0;
            for (int c = 0; c < 7; c++) begin
                case ($urandom_range(0, 6))
                    0: clamp_v = MIN_CLAMP;
                    1: clamp_v = '0;
                    2: clamp_v = t_win'($urandom_range(2, 8));
                    3: clamp_v = t_win'($urandom_range(9, 300));
                    4: clamp_v = t_win'($urandom);
                    default: clamp_v = CLAMP_RESET;
                endcase
                write_clamp(clamp_v);
                @(posedge i_clk);
                for (int k = 0; k < 48; k++) begin
                    ev.kind = ($urandom_range(0, 7) == 0) ? KIND_LOSS : KIND_ACK;
                    ev.limited = ($urandom_range(0, 7) != 0);
                    case ($urandom_range(0, 9))
                        0: ev.acked = '0;
                        1: ev.acked = '1;
                        2, 3, 4, 5: ev.acked = t_win'($urandom_range(0, 16));
                        6, 7: ev.acked = t_win'($urandom_range(0, 400));
                        default: ev.acked = t_win'($urandom);
                    endcase
                    queue_event(ev.kind, ev.acked, ev.limited);
                end
                wait_drained();
            end
        end

        err_cnt = err_cnt + wnd_thr_q.size();
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### reno_congestion_window.f
hdl/rcw_pkg.sv
hdl/reno_congestion_window.sv
tb/tb_reno_congestion_window.sv
